/* sv/srr_pkg.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Types and codes shared by the receiver modules.
// ----------------------------------------------------------------------------
package srr_pkg;

  typedef enum logic [1:0] {
    PH_INORDER = 2'd0,
    PH_BUFFER  = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_RR       = 3'd1,
    KIND_SREJ     = 3'd2,
    KIND_EOFACK   = 3'd3,
    KIND_FINISHED = 3'd4,
    KIND_DROPPED  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_HCMP,
    ST_HEXP,
    ST_HINC,
    ST_CNT,
    ST_SREJ,
    ST_INC,
    ST_RR,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } slot_ctl_t;

  localparam logic [4:0] SLOTS_RESET = 5'd16;

endpackage

/* sv/srr_if.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver channels
// Valid/ready channels for arrival requests and for result requests.
// ----------------------------------------------------------------------------
interface srr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] seq_num;
  logic        is_eof;
  logic        checksum_ok;
  logic [15:0] payload_handle;

  modport source (output valid, output mode, output seq_num, output is_eof,
                  output checksum_ok, output payload_handle, input ready);
  modport sink   (input valid, input mode, input seq_num, input is_eof,
                  input checksum_ok, input payload_handle, output ready);
endinterface

interface srr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [31:0] response_seq;
  logic        last;

  modport source (output valid, output kind, output value, output response_seq,
                  output last, input ready);
  modport sink   (input valid, input kind, input value, input response_seq,
                  input last, output ready);
endinterface

/* sv/srr_alu.sv */
// ----------------------------------------------------------------------------
// Shared adder
// One 33-bit add/subtract used for every sequence-number compare and step.
// ----------------------------------------------------------------------------
module srr_alu
  import srr_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] res,
  output logic        cout,
  output logic        zero
);

  logic [31:0] b_op;

  // On subtract, carry out high means no borrow, that is a >= b.
  assign b_op        = sub ? ~b : b;
  assign {cout, res} = {1'b0, a} + {1'b0, b_op} + {32'd0, sub};
  assign zero        = (res == 32'd0);

endmodule

/* sv/srr_slots.sv */
// ----------------------------------------------------------------------------
// Reorder window store
// Valid flags in flip-flops plus a handle/EOF memory with a registered read.
// ----------------------------------------------------------------------------
module srr_slots
  import srr_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  slot_ctl_t                 ctl,
  input  logic [$clog2(WINDOW)-1:0] wr_idx,
  input  logic [15:0]               wr_handle,
  input  logic                      wr_eof,
  input  logic [$clog2(WINDOW)-1:0] clr_idx,
  input  logic [$clog2(WINDOW)-1:0] rd_idx,
  output logic                      rd_valid,
  output logic [15:0]               rd_handle,
  output logic                      rd_eof
);

  localparam int SLOT_W = $clog2(WINDOW);

  logic [WINDOW-1:0] valid_r;
  logic [16:0]       mem [WINDOW];
  logic [16:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= {wr_eof, wr_handle};
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_valid  = valid_r[rd_idx[SLOT_W-1:0]];
  assign rd_eof    = rd_data_r[16];
  assign rd_handle = rd_data_r[15:0];

endmodule

/* sv/selective_repeat_receiver.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receiver
// A request is accepted while idle and then classified; a single-result
// request is then done. A gap is answered by SREJ steps, a direct write by
// increment and RR steps, and each drained slot by drain, increment and RR.
// Throughput is set by the one shared adder that the sequencer steps through.
// Reset is synchronous: the window flags clear at once, no clearing pass.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  srr_in_if.sink       in_ch,
  srr_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);

  localparam int               SLOT_W    = $clog2(WINDOW);
  // Largest usable number of slots: the register never opens past the store.
  localparam logic [4:0]       EFF_MAX   = (WINDOW < 16) ? 5'(WINDOW) : 5'd16;
  localparam logic [SLOT_W:0]  WIN_L     = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Sequencer and protocol state.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [31:0]       exp_r, exp_nxt;
  logic [31:0]       high_r, high_nxt;
  logic [31:0]       out_seq_r, out_seq_nxt;
  logic [SLOT_W-1:0] exp_slot_r, exp_slot_nxt;
  logic [4:0]        slots_r;
  logic              drain_r, drain_nxt;

  // Captured request and loop registers.
  logic              mode_r, eof_r, ok_r;
  logic [31:0]       seq_r;
  logic [15:0]       hdl_r;
  logic [31:0]       i_r, i_nxt;
  logic [4:0]        cnt_r, cnt_nxt;

  // Output register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [31:0]       out_value_r, out_rseq_r;
  logic              out_last_r;

  // Result request built in the current cycle.
  logic              emit;
  kind_t             e_kind;
  logic [31:0]       e_value, e_rseq;
  logic              e_last;
  logic              go;

  // Shared adder.
  logic [31:0]       alu_a, alu_b, alu_res;
  logic              alu_sub, alu_cout, alu_zero;

  // Window store.
  slot_ctl_t         slot_ctl;
  logic [SLOT_W-1:0] seq_slot;
  logic              rd_valid, rd_eof;
  logic [15:0]       rd_handle;

  // Classification terms.
  logic [4:0]        eff;
  logic              c_skip, c_fin, c_old, c_beyond, c_inord;
  logic [SLOT_W:0]   slot_sum;

  srr_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .cout (alu_cout),
    .zero (alu_zero)
  );

  srr_slots #(.WINDOW(WINDOW)) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (slot_ctl),
    .wr_idx    (seq_slot),
    .wr_handle (hdl_r),
    .wr_eof    (eof_r),
    .clr_idx   (exp_slot_r),
    .rd_idx    (exp_slot_r),
    .rd_valid  (rd_valid),
    .rd_handle (rd_handle),
    .rd_eof    (rd_eof)
  );

  // The register value is clamped to at least one slot and at most the store.
  always_comb begin
    priority if (slots_r == 5'd0) begin
      eff = 5'd1;
    end else if (slots_r > EFF_MAX) begin
      eff = EFF_MAX;
    end else begin
      eff = slots_r;
    end
  end

  // Operand selection for the shared adder, one job per sequencer step.
  always_comb begin
    alu_a   = 32'd0;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_CLASSIFY: begin alu_a = seq_r;  alu_b = exp_r;  alu_sub = 1'b1; end
      ST_HCMP:     begin alu_a = high_r; alu_b = seq_r;  alu_sub = 1'b1; end
      ST_HEXP:     begin alu_a = high_r; alu_b = exp_r;  alu_sub = 1'b1; end
      ST_HINC:     begin alu_a = high_r; alu_b = 32'd1;                  end
      ST_CNT:      begin alu_a = seq_r;  alu_b = i_r;    alu_sub = 1'b1; end
      ST_SREJ:     begin alu_a = i_r;    alu_b = 32'd1;                  end
      ST_INC:      begin alu_a = exp_r;  alu_b = 32'd1;                  end
      ST_RR:       begin alu_a = high_r; alu_b = exp_r;  alu_sub = 1'b1; end
      default: begin
      end
    endcase
  end

  // In the classify step the adder holds seq_num minus expected_seq. A request
  // that passes the window checks has a distance below the slot count, which
  // is at most WINDOW, so its slot is the expected slot plus that distance,
  // folded once.
  assign c_skip   = !mode_r && !ok_r;
  assign c_fin    = (phase_r == PH_DONE) || mode_r;
  assign c_old    = !alu_cout;
  assign c_beyond = (|alu_res[31:5]) || (alu_res[4:0] >= eff);
  assign c_inord  = (phase_r == PH_INORDER);
  assign slot_sum = {1'b0, exp_slot_r} + {1'b0, alu_res[SLOT_W-1:0]};
  assign seq_slot = (slot_sum >= WIN_L) ? SLOT_W'(slot_sum - WIN_L)
                                        : slot_sum[SLOT_W-1:0];

  // A result may be issued when the output register is empty or being drained.
  assign go = !out_valid_r || out_ch.ready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        priority if (c_skip) begin
          state_nxt = ST_IDLE;
        end else if (c_fin || c_old || c_beyond) begin
          if (go) state_nxt = ST_IDLE;
        end else if (c_inord) begin
          if (!alu_zero) begin
            state_nxt = ST_SREJ;
          end else if (go) begin
            state_nxt = eof_r ? ST_IDLE : ST_INC;
          end
        end else begin
          if (!alu_zero) begin
            state_nxt = ST_HCMP;
          end else if (eof_r) begin
            state_nxt = ST_IDLE;
          end else if (go) begin
            state_nxt = ST_INC;
          end
        end
      end
      ST_HCMP: state_nxt = alu_cout ? ST_IDLE : ST_HEXP;
      ST_HEXP: state_nxt = alu_cout ? ST_HINC : ST_CNT;
      ST_HINC: state_nxt = ST_CNT;
      ST_CNT:  state_nxt = alu_zero ? ST_IDLE : ST_SREJ;
      ST_SREJ: begin
        if (go && cnt_r == 5'd1) state_nxt = ST_IDLE;
      end
      ST_INC:  state_nxt = ST_RR;
      ST_RR: begin
        if (go) begin
          if (!drain_r || !alu_cout || !rd_valid) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (go) state_nxt = rd_eof ? ST_IDLE : ST_INC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and result requests for each step.
  always_comb begin
    phase_nxt    = phase_r;
    exp_nxt      = exp_r;
    high_nxt     = high_r;
    out_seq_nxt  = out_seq_r;
    exp_slot_nxt = exp_slot_r;
    drain_nxt    = drain_r;
    i_nxt        = i_r;
    cnt_nxt      = cnt_r;
    slot_ctl     = '0;
    emit         = 1'b0;
    e_kind       = KIND_WRITE;
    e_value      = 32'd0;
    e_rseq       = 32'd0;
    e_last       = 1'b0;
    unique case (state_r)
      ST_CLASSIFY: begin
        priority if (c_skip) begin
          // A corrupt packet leaves no trace.
        end else if (c_fin) begin
          emit   = 1'b1;
          e_kind = KIND_FINISHED;
          e_last = 1'b1;
          if (go) phase_nxt = PH_DONE;
        end else if (c_old) begin
          // An old packet is answered with the number still awaited.
          emit    = 1'b1;
          e_kind  = KIND_RR;
          e_value = exp_r;
          e_rseq  = out_seq_r;
          e_last  = 1'b1;
          if (go) out_seq_nxt = out_seq_r + 32'd1;
        end else if (c_beyond) begin
          emit    = 1'b1;
          e_kind  = KIND_DROPPED;
          e_value = seq_r;
          e_last  = 1'b1;
        end else if (c_inord) begin
          if (!alu_zero) begin
            // Gap opens: hold the packet, then request every missing number.
            i_nxt        = exp_r;
            cnt_nxt      = alu_res[4:0];
            high_nxt     = seq_r;
            slot_ctl.wr_en = 1'b1;
            phase_nxt    = PH_BUFFER;
          end else if (eof_r) begin
            emit    = 1'b1;
            e_kind  = KIND_EOFACK;
            e_value = seq_r;
            e_rseq  = out_seq_r;
            e_last  = 1'b1;
            if (go) phase_nxt = PH_DONE;
          end else begin
            emit    = 1'b1;
            e_kind  = KIND_WRITE;
            e_value = {16'd0, hdl_r};
            if (go) begin
              high_nxt  = seq_r;
              drain_nxt = 1'b0;
            end
          end
        end else begin
          if (!alu_zero) begin
            slot_ctl.wr_en = 1'b1;
          end else if (!eof_r) begin
            // The missing packet arrived: write it and start the flush.
            emit    = 1'b1;
            e_kind  = KIND_WRITE;
            e_value = {16'd0, hdl_r};
            if (go) begin
              slot_ctl.clr_en = 1'b1;
              drain_nxt       = 1'b1;
            end
          end
        end
      end
      ST_HEXP: begin
        // When the highest number lies behind the expected one, the new gap
        // starts at the expected number.
        if (!alu_cout) i_nxt = exp_r;
      end
      ST_HINC: i_nxt = alu_res;
      ST_CNT: begin
        high_nxt = seq_r;
        cnt_nxt  = alu_res[4:0];
      end
      ST_SREJ: begin
        emit    = 1'b1;
        e_kind  = KIND_SREJ;
        e_value = i_r;
        e_rseq  = out_seq_r;
        e_last  = (cnt_r == 5'd1);
        if (go) begin
          out_seq_nxt = out_seq_r + 32'd1;
          i_nxt       = alu_res;
          cnt_nxt     = cnt_r - 5'd1;
        end
      end
      ST_INC: begin
        exp_nxt = alu_res;
        // On a wrap of the sequence number, or past the last slot, the slot index restarts at zero.
        priority if (alu_cout || exp_slot_r == SLOT_LAST) begin
          exp_slot_nxt = '0;
        end else begin
          exp_slot_nxt = exp_slot_r + SLOT_W'(1);
        end
      end
      ST_RR: begin
        emit    = 1'b1;
        e_kind  = KIND_RR;
        e_value = exp_r;
        e_rseq  = out_seq_r;
        e_last  = !drain_r || !alu_cout || !rd_valid;
        if (go) begin
          out_seq_nxt = out_seq_r + 32'd1;
          if (drain_r && !alu_cout) phase_nxt = PH_INORDER;
        end
      end
      ST_DRAIN: begin
        emit = 1'b1;
        if (rd_eof) begin
          e_kind  = KIND_EOFACK;
          e_value = exp_r;
          e_rseq  = out_seq_r;
          e_last  = 1'b1;
          if (go) phase_nxt = PH_DONE;
        end else begin
          e_kind  = KIND_WRITE;
          e_value = {16'd0, rd_handle};
        end
        if (go) slot_ctl.clr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_INORDER;
      exp_r       <= 32'd0;
      high_r      <= 32'd0;
      out_seq_r   <= 32'd1;
      exp_slot_r  <= '0;
      slots_r     <= SLOTS_RESET;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      exp_r      <= exp_nxt;
      high_r     <= high_nxt;
      out_seq_r  <= out_seq_nxt;
      exp_slot_r <= exp_slot_nxt;
      drain_r    <= drain_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
      if (emit && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      mode_r <= in_ch.mode;
      seq_r  <= in_ch.seq_num;
      eof_r  <= in_ch.is_eof;
      ok_r   <= in_ch.checksum_ok;
      hdl_r  <= in_ch.payload_handle;
    end
    i_r   <= i_nxt;
    cnt_r <= cnt_nxt;
    if (emit && go) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_rseq_r  <= e_rseq;
      out_last_r  <= e_last;
    end
  end

  // A new request is taken whenever the sequencer is idle, even while the
  // last result still waits in the output register.
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.response_seq = out_rseq_r;
  assign out_ch.last         = out_last_r;

endmodule
